/* rtl/msh_pkg.sv */
// shared types and constants for the mirrored bilinear height sampler
// no dependencies; imported by every rtl module of the block but msh_ram
package msh_pkg;

    localparam int MAX_DIM         = 257;
    localparam int COORD_FRAC_BITS = 8;
    localparam int WEIGHT_BITS     = 16;
    localparam int DEPTH           = MAX_DIM * MAX_DIM;
    localparam int ADDR_W          = $clog2(DEPTH);

    localparam int SAMPLE_W      = 16;
    localparam int SAMPLE_ADDR_W = 17;
    localparam int COORD_W       = 24;
    localparam int STEP_W        = 9;
    localparam int COUNT_W       = 9;
    localparam int OFFSET_W      = 16;
    localparam int HEIGHT_W      = 28;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COL_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd3;

    localparam logic [OFFSET_W-1:0] COL_OFFSET_RST = 16'd1356;
    localparam logic [OFFSET_W-1:0] ROW_OFFSET_RST = 16'd924;
    localparam logic [COUNT_W-1:0]  COUNT_RST      = 9'd257;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // divider sizing
    localparam int DIV_W    = 25;
    localparam int DIVR_W   = 9;
    localparam int DIVCNT_W = 5;

    localparam int SEL_W   = 3;
    localparam int BLEND_W = 3;

    typedef enum logic [SEL_W-1:0] {
        DS_COL_STEP,
        DS_ROW_STEP,
        DS_COL_WT,
        DS_ROW_WT,
        DS_COL0,
        DS_COL1,
        DS_ROW0,
        DS_ROW1
    } t_div_sel;

    typedef enum logic [BLEND_W-1:0] {
        BL_NONE,
        BL_TOP,
        BL_BOT,
        BL_DIFF,
        BL_PLO,
        BL_PHI,
        BL_SUM
    } t_blend_op;

    typedef struct packed {
        logic      load_wr;
        logic      capture;
        logic      div_start;
        t_div_sel  div_sel;
        logic      rd_en;
        logic [1:0] rd_corner;
        logic      rd_latch;
        t_blend_op blend;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

/* rtl/msh_ram.sv */
// generic single-port ram with registered read
// no dependencies
module msh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/msh_div.sv */
// restoring unsigned divider, one quotient bit per cycle, variable bit count
// depends on msh_pkg
module msh_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [msh_pkg::DIV_W-1:0]      i_dividend,
    input  logic [msh_pkg::DIVR_W-1:0]     i_divisor,
    input  logic [msh_pkg::DIVCNT_W-1:0]   i_nbits,
    output logic                           o_done,
    output logic [msh_pkg::DIV_W-1:0]      o_quot,
    output logic [msh_pkg::DIVR_W-1:0]     o_rem
);
    import msh_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [DIVCNT_W-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]    r_q, n_q;
    logic [DIVR_W-1:0]   r_r, n_r;
    logic [DIVR_W-1:0]   r_d, n_d;
    logic [DIVR_W:0]     trial;
    logic                qbit;

    always_comb begin
        trial  = {r_r, r_q[DIV_W-1]};
        qbit   = (trial >= {1'b0, r_d});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        if (i_start) begin
            // left-align the dividend so only i_nbits steps are needed
            n_q    = i_dividend << (DIVCNT_W'(DIV_W) - i_nbits);
            n_r    = '0;
            n_d    = i_divisor;
            n_cnt  = i_nbits;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_r   = qbit ? DIVR_W'(trial - {1'b0, r_d}) : trial[DIVR_W-1:0];
            n_q   = {r_q[DIV_W-2:0], qbit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DIVCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_r < r_d)) else $error("remainder not below divisor");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> (!r_done && !r_busy)) else $error("done not a single pulse");

endmodule

/* rtl/msh_dp.sv */
// datapath: config registers, height store, shared divider, blend arithmetic
// depends on msh_pkg, msh_ram, msh_div
module msh_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [msh_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [msh_pkg::CFG_DATA_W-1:0]          i_cfg_data,
    input  logic [msh_pkg::SAMPLE_ADDR_W-1:0]       i_sample_address,
    input  logic signed [msh_pkg::SAMPLE_W-1:0]     i_sample_value,
    input  logic signed [msh_pkg::COORD_W-1:0]      i_query_col,
    input  logic signed [msh_pkg::COORD_W-1:0]      i_query_row,
    input  logic [msh_pkg::STEP_W-1:0]              i_query_step,
    input  msh_pkg::t_cmd                           i_cmd,
    output msh_pkg::t_status                        o_status,
    output logic signed [msh_pkg::HEIGHT_W-1:0]     o_height
);
    import msh_pkg::*;

    localparam int FC_W    = COORD_W - COORD_FRAC_BITS;
    localparam int ORG_W   = FC_W + 1;
    localparam int WT_W    = WEIGHT_BITS + 2;
    localparam int TOP_W   = 36;
    localparam int DIFF_W  = TOP_W + 1;
    localparam int LO_W    = 18;
    localparam int PROD_W  = DIFF_W;
    localparam int TOT_W   = 56;
    localparam int SHIFT   = 2 * WEIGHT_BITS - COORD_FRAC_BITS;
    localparam logic signed [TOT_W-SHIFT-1:0] H_MAX = (TOT_W-SHIFT)'((64'sd1 <<< 27) - 1);
    localparam logic signed [TOT_W-SHIFT-1:0] H_MIN = (TOT_W-SHIFT)'(-(64'sd1 <<< 27));

    // config
    logic [OFFSET_W-1:0] r_col_off, r_row_off;
    logic [COUNT_W-1:0]  r_col_cnt, r_row_cnt;
    logic [COUNT_W-1:0]  cdim, rdim;

    // query state
    logic signed [COORD_W-1:0] r_qc, r_qr;
    logic [STEP_W-1:0]         r_step;
    logic signed [ORG_W-1:0]   r_c0, r_r0;
    logic signed [WT_W-1:0]    r_wx, r_wy;
    logic [COUNT_W-1:0]        r_mc0, r_mc1, r_mr0, r_mr1;
    logic signed [SAMPLE_W-1:0] r_h [4];
    logic signed [TOP_W-1:0]   r_top, r_bot;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [PROD_W-1:0]  r_plo, r_phi;
    logic signed [TOT_W-1:0]   r_total;
    logic signed [HEIGHT_W-1:0] r_height;
    t_div_sel                  r_sel;
    logic                      r_neg;
    logic [1:0]                r_corner;

    // divider hookup
    logic [DIV_W-1:0]    div_dvd;
    logic [DIVR_W-1:0]   div_dvs;
    logic [DIVCNT_W-1:0] div_n;
    logic                div_neg;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;
    logic [DIVR_W-1:0]   div_r;

    // source terms
    logic signed [FC_W-1:0]    fcoord;
    logic signed [ORG_W-1:0]   fcx;
    logic signed [COORD_W:0]   dcoord;
    logic [COORD_W:0]          dabs;
    logic signed [ORG_W-1:0]   org;
    logic [OFFSET_W-1:0]       off;
    logic signed [ORG_W:0]     corner;
    logic [ORG_W-1:0]          cabs;

    // result terms
    logic signed [ORG_W:0]     qsig;
    logic signed [ORG_W+STEP_W+1:0] oprod;
    logic signed [WT_W-1:0]    wsig;
    logic [COUNT_W-1:0]        dsel;
    logic [COUNT_W-1:0]        mirr;

    // store
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_addr;
    logic [SAMPLE_W-1:0]     ram_rdata;
    logic [COUNT_W-1:0]      rd_c, rd_r;
    logic [2*COUNT_W-1:0]    rowbase;
    logic [ADDR_W-1:0]       rd_addr;

    // blend
    logic signed [SAMPLE_W:0]  dh_top, dh_bot;
    logic signed [TOP_W-1:0]   pw_top, pw_bot;
    logic signed [TOT_W-SHIFT-1:0] hfull;

    always_comb begin
        cdim = (r_col_cnt == '0) ? COUNT_W'(1) :
               (r_col_cnt > COUNT_W'(MAX_DIM)) ? COUNT_W'(MAX_DIM) : r_col_cnt;
        rdim = (r_row_cnt == '0) ? COUNT_W'(1) :
               (r_row_cnt > COUNT_W'(MAX_DIM)) ? COUNT_W'(MAX_DIM) : r_row_cnt;
    end

    // divider operand select
    always_comb begin
        unique case (i_cmd.div_sel)
            DS_COL_STEP, DS_COL_WT, DS_COL0, DS_COL1: begin
                fcoord = r_qc[COORD_W-1:COORD_FRAC_BITS];
                org    = r_c0;
                off    = r_col_off;
                dcoord = (COORD_W+1)'(r_qc) - $signed({r_c0, 8'd0});
            end
            default: begin
                fcoord = r_qr[COORD_W-1:COORD_FRAC_BITS];
                org    = r_r0;
                off    = r_row_off;
                dcoord = (COORD_W+1)'(r_qr) - $signed({r_r0, 8'd0});
            end
        endcase
        fcx    = ORG_W'(fcoord);
        dabs   = dcoord[COORD_W] ? (COORD_W+1)'(-dcoord) : dcoord;
        corner = (ORG_W+1)'(org) + $signed({2'b00, off});
        if (i_cmd.div_sel == DS_COL1 || i_cmd.div_sel == DS_ROW1) begin
            corner = corner + $signed({{(ORG_W+1-STEP_W){1'b0}}, r_step});
        end
        cabs = corner[ORG_W] ? ORG_W'(-corner) : corner[ORG_W-1:0];

        unique case (i_cmd.div_sel)
            DS_COL_STEP, DS_ROW_STEP: begin
                div_dvd = DIV_W'(fcx[ORG_W-1] ? -fcx : fcx);
                div_dvs = r_step;
                div_n   = DIVCNT_W'(ORG_W);
                div_neg = fcx[ORG_W-1];
            end
            DS_COL_WT, DS_ROW_WT: begin
                div_dvd = {dabs[ORG_W-1:0], 8'd0};
                div_dvs = r_step;
                div_n   = DIVCNT_W'(DIV_W);
                div_neg = dcoord[COORD_W];
            end
            DS_COL0, DS_COL1: begin
                div_dvd = DIV_W'(cabs);
                div_dvs = cdim;
                div_n   = DIVCNT_W'(ORG_W);
                div_neg = 1'b0;
            end
            default: begin
                div_dvd = DIV_W'(cabs);
                div_dvs = rdim;
                div_n   = DIVCNT_W'(ORG_W);
                div_neg = 1'b0;
            end
        endcase
    end

    msh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_nbits    (div_n),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // divider result terms
    always_comb begin
        qsig  = r_neg ? -$signed({2'b00, div_q[ORG_W-2:0]}) : $signed({2'b00, div_q[ORG_W-2:0]});
        oprod = qsig * $signed({1'b0, r_step});
        wsig  = r_neg ? -$signed({1'b0, div_q[WT_W-2:0]}) : $signed({1'b0, div_q[WT_W-2:0]});
        dsel  = (r_sel == DS_COL0 || r_sel == DS_COL1) ? cdim : rdim;
        // odd periods reflect
        mirr  = div_q[0] ? COUNT_W'(dsel - COUNT_W'(1) - div_r) : div_r;
    end

    // store address
    always_comb begin
        rd_c    = i_cmd.rd_corner[0] ? r_mc1 : r_mc0;
        rd_r    = i_cmd.rd_corner[1] ? r_mr1 : r_mr0;
        rowbase = rd_r * cdim;
        rd_addr = ADDR_W'(rowbase) + ADDR_W'(rd_c);
        ram_we  = i_cmd.load_wr && (i_sample_address < SAMPLE_ADDR_W'(DEPTH));
        ram_addr = i_cmd.rd_en ? rd_addr : ADDR_W'(i_sample_address);
    end

    msh_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_sample_value),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        dh_top = (SAMPLE_W+1)'(r_h[1]) - (SAMPLE_W+1)'(r_h[0]);
        dh_bot = (SAMPLE_W+1)'(r_h[3]) - (SAMPLE_W+1)'(r_h[2]);
        // 17 x 18 signed products, sized to the row sum
        pw_top = dh_top * r_wx;
        pw_bot = dh_bot * r_wx;
        hfull  = r_total[TOT_W-1:SHIFT];
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_off <= COL_OFFSET_RST;
            r_row_off <= ROW_OFFSET_RST;
            r_col_cnt <= COUNT_RST;
            r_row_cnt <= COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COL_OFFSET: r_col_off <= i_cfg_data;
                CFG_ROW_OFFSET: r_row_off <= i_cfg_data;
                CFG_COL_COUNT:  r_col_cnt <= i_cfg_data[COUNT_W-1:0];
                default:        r_row_cnt <= i_cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qc   <= i_query_col;
            r_qr   <= i_query_row;
            r_step <= (i_query_step == '0) ? STEP_W'(1) : i_query_step;
        end
        if (i_cmd.div_start) begin
            r_sel <= i_cmd.div_sel;
            r_neg <= div_neg;
        end
        if (div_done) begin
            unique case (r_sel)
                DS_COL_STEP: r_c0  <= oprod[ORG_W-1:0];
                DS_ROW_STEP: r_r0  <= oprod[ORG_W-1:0];
                DS_COL_WT:   r_wx  <= wsig;
                DS_ROW_WT:   r_wy  <= wsig;
                DS_COL0:     r_mc0 <= mirr;
                DS_COL1:     r_mc1 <= mirr;
                DS_ROW0:     r_mr0 <= mirr;
                default:     r_mr1 <= mirr;
            endcase
        end
        if (i_cmd.rd_en) begin
            r_corner <= i_cmd.rd_corner;
        end
        if (i_cmd.rd_latch) begin
            r_h[r_corner] <= ram_rdata;
        end
        unique case (i_cmd.blend)
            BL_TOP:  r_top <= (TOP_W'(r_h[0]) <<< WEIGHT_BITS) + pw_top;
            BL_BOT:  r_bot <= (TOP_W'(r_h[2]) <<< WEIGHT_BITS) + pw_bot;
            BL_DIFF: r_diff <= DIFF_W'(r_bot) - DIFF_W'(r_top);
            BL_PLO:  r_plo <= $signed({1'b0, r_diff[LO_W-1:0]}) * r_wy;
            BL_PHI:  r_phi <= $signed(r_diff[DIFF_W-1:LO_W]) * r_wy;
            BL_SUM:  r_total <= (TOT_W'(r_top) <<< WEIGHT_BITS) + (TOT_W'(r_phi) <<< LO_W)
                                + TOT_W'(r_plo);
            default: ;
        endcase
        if (i_cmd.out_load) begin
            if (hfull > H_MAX) begin
                r_height <= HEIGHT_W'(H_MAX);
            end else if (hfull < H_MIN) begin
                r_height <= HEIGHT_W'(H_MIN);
            end else begin
                r_height <= HEIGHT_W'(hfull);
            end
        end
    end

    assign o_status.div_done = div_done;
    assign o_height          = r_height;

endmodule

/* rtl/msh_ctrl.sv */
// sequencer for loads and queries, owns the output valid flag
// depends on msh_pkg
module msh_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_command,
    input  logic            i_out_stall,
    input  msh_pkg::t_status i_status,
    output logic            o_stall,
    output logic            o_out_valid,
    output msh_pkg::t_cmd   o_cmd
);
    import msh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RD_ISSUE,
        S_RD_LATCH,
        S_BLEND,
        S_OUT
    } t_state;

    t_state    r_state, n_state;
    t_div_sel  r_sel, n_sel;
    logic [1:0] r_corner, n_corner;
    t_blend_op r_blend, n_blend;
    logic      r_out_valid, n_out_valid;
    logic      accept;
    logic      out_free;

    always_comb begin
        accept      = i_valid && (r_state == S_IDLE);
        out_free    = !r_out_valid || !i_out_stall;
        n_state     = r_state;
        n_sel       = r_sel;
        n_corner    = r_corner;
        n_blend     = r_blend;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd           = '0;
        o_cmd.div_sel   = r_sel;
        o_cmd.rd_corner = r_corner;
        o_cmd.blend     = BL_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command == CMD_QUERY) begin
                        o_cmd.capture = 1'b1;
                        n_sel   = DS_COL_STEP;
                        n_state = S_DIV_GO;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    if (r_sel == DS_ROW1) begin
                        n_corner = 2'd0;
                        n_state  = S_RD_ISSUE;
                    end else begin
                        n_sel   = t_div_sel'(SEL_W'(r_sel + SEL_W'(1)));
                        n_state = S_DIV_GO;
                    end
                end
            end
            S_RD_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_RD_LATCH;
            end
            S_RD_LATCH: begin
                o_cmd.rd_latch = 1'b1;
                if (r_corner == 2'd3) begin
                    n_blend = BL_TOP;
                    n_state = S_BLEND;
                end else begin
                    n_corner = r_corner + 2'd1;
                    n_state  = S_RD_ISSUE;
                end
            end
            S_BLEND: begin
                o_cmd.blend = r_blend;
                if (r_blend == BL_SUM) begin
                    n_state = S_OUT;
                end else begin
                    n_blend = t_blend_op'(BLEND_W'(r_blend + BLEND_W'(1)));
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sel       <= DS_COL_STEP;
            r_corner    <= 2'd0;
            r_blend     <= BL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_corner    <= n_corner;
            r_blend     <= n_blend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/mirrored_bilinear_height_sampler.sv */
// top level of the mirrored bilinear height sampler
// depends on msh_pkg, msh_ctrl, msh_dp (which holds msh_div and msh_ram)
//
// usage
//   input channel: i_valid / o_stall carry one word per accept. a word with
//   i_command low writes i_sample_value into the height store at
//   i_sample_address (addresses past the store are dropped), with no
//   result. a word with i_command high is a query.
//   output channel: o_valid / i_stall carry the 28-bit q.8 o_height word,
//   one per query, in query order.
//   config channel: i_cfg_valid / o_cfg_ready (always ready) write the
//   offset and count registers; write only while the block is idle.
//   a query runs eight divisions, one after another, on the shared
//   one-bit-per-cycle divider (two origin and four mirror divisions of
//   17 bits, two weight divisions of 25 bits), then four store reads on
//   the single ram port, six blend steps and one output load; no new word
//   is taken until the query has made its output load.
//   while a query is in flight o_stall is high.
//   reset: synchronous, active low; control and config registers go back
//   to defaults and the output word drops. the height store is not cleared.
//   a stalled output word holds; a new word is accepted meanwhile, and a
//   finished query waits in place until the output register frees up.
module mirrored_bilinear_height_sampler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic [msh_pkg::SAMPLE_ADDR_W-1:0]   i_sample_address,
    input  logic signed [msh_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic signed [msh_pkg::COORD_W-1:0]  i_query_col,
    input  logic signed [msh_pkg::COORD_W-1:0]  i_query_row,
    input  logic [msh_pkg::STEP_W-1:0]          i_query_step,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [msh_pkg::HEIGHT_W-1:0] o_height,
    // config channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [msh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [msh_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import msh_pkg::*;

    t_cmd    cmd;
    t_status status;

    // config writes are registered directly, so the port never pushes back
    assign o_cfg_ready = 1'b1;

    msh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_command   (i_command),
        .i_out_stall (i_stall),
        .i_status    (status),
        .o_stall     (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    msh_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample_address (i_sample_address),
        .i_sample_value   (i_sample_value),
        .i_query_col      (i_query_col),
        .i_query_row      (i_query_row),
        .i_query_step     (i_query_step),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_height         (o_height)
    );

endmodule
